// ===== hw/rtl/dgc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgc_pkg
// Shared types and constants for the dynamic graph connectivity block.
// ----------------------------------------------------------------------------
package dgc_pkg;

    // default configuration
    localparam int DEF_VERTICES   = 64;
    localparam int DEF_COUNT_BITS = 4;

    // fixed port widths
    localparam int CMD_W    = 2;
    localparam int VERTEX_W = 6;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_A,
        ST_UPD_B,
        ST_QUERY
    } t_state;

    // control from the sequencer to the search sets
    typedef struct packed {
        logic seed;
        logic pop;
        logic absorb;
    } t_front_ctl;

    // status from the search sets back to the sequencer
    typedef struct packed {
        logic any;
        logic hit;
    } t_front_stat;

endpackage

// ===== hw/rtl/dynamic_graph_connectivity.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dynamic_graph_connectivity
// Undirected multigraph with edge add, edge remove and connectivity query.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfers at a rising edge with start high and busy low:
//   i_command, i_vertex_a, i_vertex_b. Add and remove produce no result;
//   a query produces one result on o_connected, marked by o_valid for
//   exactly one cycle. The receiver cannot stall; it must take the result.
// Timing:
//   add / remove in range: busy in ST_UPD_A, then ST_UPD_B (read row a,
//     write row a and read row b, write row b) - set by the write port.
//   query with an operand out of range or vertex_a equal to vertex_b:
//     result in the next cycle, no busy time.
//   query: one memory row read per expanded vertex; o_valid rises as busy
//     falls.
// Reset:
//   i_rst_n is synchronous, active low. After reset the edge memory is
//   cleared one row a cycle with busy held high.
// ----------------------------------------------------------------------------
module dynamic_graph_connectivity
    import dgc_pkg::*;
#(
    parameter int VERTICES   = DEF_VERTICES,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [VERTEX_W-1:0] i_vertex_a,
    input  logic [VERTEX_W-1:0] i_vertex_b,
    output logic                o_valid,
    output logic                o_connected
);

    localparam int VW    = $clog2(VERTICES);
    localparam int ROW_W = VERTICES * COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    t_state              r_state, n_state;
    logic [VW-1:0]       r_clr, n_clr;
    logic [VW-1:0]       r_a, n_a;
    logic [VW-1:0]       r_b, n_b;
    logic                r_add, n_add;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_pend, n_pend;
    logic                r_valid, n_valid;
    logic                r_conn, n_conn;

    logic                mem_wr_en;
    logic [VW-1:0]       mem_wr_addr;
    logic [ROW_W-1:0]    mem_wr_data;
    logic [VW-1:0]       mem_rd_addr;
    logic [ROW_W-1:0]    mem_rd_data;

    t_front_ctl          f_ctl;
    t_front_stat         f_stat;
    logic [VW-1:0]       f_pick;
    logic [VERTICES-1:0] row_mask;

    logic                accept;
    t_cmd                cmd;
    logic                in_range;
    logic [VW-1:0]       idx_a;
    logic [VW-1:0]       idx_b;
    logic [COUNT_BITS-1:0] old_cnt;
    logic [COUNT_BITS-1:0] new_cnt;

    // command decode
    assign accept   = start && !busy;
    assign cmd      = t_cmd'(i_command);
    assign in_range = (32'(i_vertex_a) < VERTICES) && (32'(i_vertex_b) < VERTICES);
    assign idx_a    = VW'(32'(i_vertex_a));
    assign idx_b    = VW'(32'(i_vertex_b));

    // nonzero lanes of the row read back
    always_comb begin
        for (int i = 0; i < VERTICES; i++) begin
            row_mask[i] = |mem_rd_data[i*COUNT_BITS +: COUNT_BITS];
        end
    end

    // saturating count update on row a
    assign old_cnt = mem_rd_data[int'(r_b)*COUNT_BITS +: COUNT_BITS];

    always_comb begin
        new_cnt = old_cnt;
        if (r_add) begin
            if (old_cnt != COUNT_MAX) begin
                new_cnt = old_cnt + COUNT_BITS'(1);
            end
        end else if (old_cnt != '0) begin
            new_cnt = old_cnt - COUNT_BITS'(1);
        end
    end

    // sequencer next state and outputs
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_a         = r_a;
        n_b         = r_b;
        n_add       = r_add;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_valid     = 1'b0;
        n_conn      = r_conn;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_a;
        mem_wr_data = mem_rd_data;
        mem_rd_addr = r_a;
        f_ctl       = '0;

        unique case (r_state)
            ST_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_clr;
                mem_wr_data = '0;
                n_clr       = r_clr + VW'(1);
                if (r_clr == VW'(VERTICES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_a = idx_a;
                    n_b = idx_b;
                    unique case (cmd)
                        CMD_ADD, CMD_REMOVE: begin
                            n_add       = (cmd == CMD_ADD);
                            mem_rd_addr = idx_a;
                            if (in_range) begin
                                n_state = ST_UPD_A;
                            end
                        end
                        CMD_QUERY: begin
                            if (!in_range) begin
                                n_valid = 1'b1;
                                n_conn  = 1'b0;
                            end else if (idx_a == idx_b) begin
                                n_valid = 1'b1;
                                n_conn  = 1'b1;
                            end else begin
                                f_ctl.seed = 1'b1;
                                n_pend     = 1'b0;
                                n_state    = ST_QUERY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_UPD_A: begin
                // write row a, fetch row b
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_a;
                mem_wr_data = mem_rd_data;
                mem_wr_data[int'(r_b)*COUNT_BITS +: COUNT_BITS] = new_cnt;
                mem_rd_addr = r_b;
                n_cnt       = new_cnt;
                n_state     = ST_UPD_B;
            end
            ST_UPD_B: begin
                // mirror entry in row b
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_b;
                mem_wr_data = mem_rd_data;
                mem_wr_data[int'(r_a)*COUNT_BITS +: COUNT_BITS] = r_cnt;
                n_state     = ST_IDLE;
            end
            ST_QUERY: begin
                f_ctl.absorb = r_pend;
                mem_rd_addr  = f_pick;
                if (r_pend && f_stat.hit) begin
                    n_valid = 1'b1;
                    n_conn  = 1'b1;
                    n_pend  = 1'b0;
                    n_state = ST_IDLE;
                end else if (f_stat.any) begin
                    f_ctl.pop = 1'b1;
                    n_pend    = 1'b1;
                end else if (r_pend) begin
                    // absorb the row in flight, then look at the frontier again
                    n_pend = 1'b0;
                end else begin
                    n_valid = 1'b1;
                    n_conn  = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    // operand and result payload registers
    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_add  <= n_add;
        r_cnt  <= n_cnt;
        r_conn <= n_conn;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_valid     = r_valid;
    assign o_connected = r_conn;

    dgc_edge_mem #(
        .VERTICES   (VERTICES),
        .COUNT_BITS (COUNT_BITS)
    ) u_edge_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    dgc_frontier #(
        .VERTICES (VERTICES)
    ) u_frontier (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (f_ctl),
        .i_seed_idx (idx_a),
        .i_dst      (r_b),
        .i_mask     (row_mask),
        .o_pick     (f_pick),
        .o_stat     (f_stat)
    );

`ifndef SYNTHESIS
    // an in-range update transfer starts the two-row read-modify-write
    a_upd_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_range && (i_command == CMD_ADD || i_command == CMD_REMOVE))
        |=> (r_state == ST_UPD_A))
        else $error("update transfer did not start the row update");

    // row a write is always followed by the mirrored row b write
    a_upd_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD_A) |=> (r_state == ST_UPD_B))
        else $error("mirrored row write skipped");

    // a result only follows a query transfer or the end of a search
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state == ST_QUERY)
                     || $past(accept && i_command == CMD_QUERY)))
        else $error("result strobe without a query");

    // a pending row read always comes from a pop during the search
    a_pend_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ($past(r_state == ST_QUERY) && $past(f_ctl.pop)))
        else $error("row read pending without a frontier pop");
`endif

endmodule

// ===== hw/rtl/dgc_edge_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgc_edge_mem
// Edge count memory: one row per vertex holding the counts to every vertex.
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dgc_edge_mem
    import dgc_pkg::*;
#(
    parameter int VERTICES   = DEF_VERTICES,
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    localparam int VW        = $clog2(VERTICES),
    localparam int ROW_W     = VERTICES * COUNT_BITS
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [VW-1:0]    i_wr_addr,
    input  logic [ROW_W-1:0] i_wr_data,
    input  logic [VW-1:0]    i_rd_addr,
    output logic [ROW_W-1:0] o_rd_data
);

    logic [ROW_W-1:0] r_mem [VERTICES];
    logic [ROW_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, old data on a same-cycle write
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/dgc_frontier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgc_frontier
// Visited and frontier sets of the reachability search, with the picker
// that selects the next frontier vertex to expand.
// ----------------------------------------------------------------------------
module dgc_frontier
    import dgc_pkg::*;
#(
    parameter int VERTICES = DEF_VERTICES,
    localparam int VW      = $clog2(VERTICES)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_front_ctl          i_ctl,
    input  logic [VW-1:0]       i_seed_idx,
    input  logic [VW-1:0]       i_dst,
    input  logic [VERTICES-1:0] i_mask,
    output logic [VW-1:0]       o_pick,
    output t_front_stat         o_stat
);

    logic [VERTICES-1:0] r_visited;
    logic [VERTICES-1:0] r_frontier;
    logic [VERTICES-1:0] n_visited;
    logic [VERTICES-1:0] n_frontier;
    logic [VERTICES-1:0] fresh;
    logic [VERTICES-1:0] lowest;
    logic [VERTICES-1:0] seed_bit;

    // newly reached vertices from the row just read
    assign fresh    = i_mask & ~r_visited;
    assign seed_bit = VERTICES'(1) << i_seed_idx;

    // isolate the lowest frontier bit and encode it
    assign lowest = r_frontier & (~r_frontier + VERTICES'(1));

    always_comb begin
        o_pick = '0;
        for (int i = 0; i < VERTICES; i++) begin
            if (lowest[i]) begin
                o_pick = o_pick | VW'(i);
            end
        end
    end

    assign o_stat.any = |r_frontier;
    assign o_stat.hit = i_ctl.absorb && fresh[i_dst];

    // set update
    always_comb begin
        n_visited  = r_visited;
        n_frontier = r_frontier;
        if (i_ctl.seed) begin
            n_visited  = seed_bit;
            n_frontier = seed_bit;
        end else begin
            if (i_ctl.pop) begin
                n_frontier = n_frontier & ~lowest;
            end
            if (i_ctl.absorb) begin
                n_visited  = n_visited | fresh;
                n_frontier = n_frontier | fresh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited  <= '0;
            r_frontier <= '0;
        end else begin
            r_visited  <= n_visited;
            r_frontier <= n_frontier;
        end
    end

endmodule
